// ----- rtl/cfq_pkg.sv -----
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types and constants for the circular FIFO queue: request and
// result payloads, command and status codes, the front-to-back op and control.
// ----------------------------------------------------------------------------
package cfq_pkg;

  localparam int MaxDepth = 16;
  localparam int IdxW     = $clog2(MaxDepth);
  localparam int CapW     = 5;
  localparam int CntW     = 5;
  localparam int DataW    = 32;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  // Command codes of the request.
  localparam logic [1:0] CmdEnq  = 2'd0;
  localparam logic [1:0] CmdDeq  = 2'd1;
  localparam logic [1:0] CmdPeek = 2'd2;

  // Status codes of the result.
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  // Register index of the capacity register.
  localparam logic RegCapacity = 1'b0;

  typedef enum logic [1:0] {
    OpNop,
    OpEnq,
    OpDeq,
    OpPeek
  } op_kind_e;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [DataW-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] data_out;
    logic [1:0]              status;
    logic [CntW-1:0]         occupancy;
    logic                    full_flag;
    logic                    empty_flag;
  } out_t;

  typedef struct packed {
    op_kind_e                kind;
    logic signed [DataW-1:0] data;
  } op_t;

  // Control from the register block to the execution back end.
  typedef struct packed {
    logic            clr;
    logic [CapW-1:0] cap;
  } ctrl_t;

endpackage

// ----- rtl/cfq_front.sv -----
// ----------------------------------------------------------------------------
// cfq_front
// Accepts requests and classifies each command into an operation for the
// back end. Unknown command codes become a no-op.
// ----------------------------------------------------------------------------
module cfq_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cfq_pkg::in_t  in_data_i,
  output logic          op_valid_o,
  input  logic          op_ready_i,
  output cfq_pkg::op_t  op_o
);

  assign in_ready_o = op_ready_i;
  assign op_valid_o = in_valid_i;

  always_comb begin
    op_o.data = in_data_i.data_in;
    unique case (in_data_i.command)
      cfq_pkg::CmdEnq:  op_o.kind = cfq_pkg::OpEnq;
      cfq_pkg::CmdDeq:  op_o.kind = cfq_pkg::OpDeq;
      cfq_pkg::CmdPeek: op_o.kind = cfq_pkg::OpPeek;
      default:          op_o.kind = cfq_pkg::OpNop;
    endcase
  end

endmodule

// ----- rtl/cfq_op_queue.sv -----
// ----------------------------------------------------------------------------
// cfq_op_queue
// Two-entry queue of classified operations between the front and the back
// end, so that either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module cfq_op_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  cfq_pkg::op_t  push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output cfq_pkg::op_t  pop_op_o
);

  cfq_pkg::op_t ent_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_op_o     = ent_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ----- rtl/cfq_back.sv -----
// ----------------------------------------------------------------------------
// cfq_back
// Executes one operation per cycle unless its result is held, against the
// slot store, head and tail indices and occupancy; holds the result register.
// ----------------------------------------------------------------------------
module cfq_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfq_pkg::ctrl_t ctrl_i,
  input  logic           op_valid_i,
  output logic           op_ready_o,
  input  cfq_pkg::op_t   op_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cfq_pkg::out_t  out_data_o
);

  logic signed [cfq_pkg::DataW-1:0] slot_q [cfq_pkg::MaxDepth];
  logic [cfq_pkg::IdxW-1:0]         head_q, head_d;
  logic [cfq_pkg::IdxW-1:0]         tail_q, tail_d;
  logic [cfq_pkg::CntW-1:0]         cnt_q, cnt_d;
  logic                             out_valid_q, out_valid_d;
  cfq_pkg::out_t                    out_q, out_d;
  logic                             fire;
  logic                             is_full, is_empty;
  logic                             wr_en;
  logic [cfq_pkg::CapW-1:0]         cap_m1;

  // Step an index by one, wrapping at the configured capacity.
  function automatic logic [cfq_pkg::IdxW-1:0] next_idx(
    input logic [cfq_pkg::IdxW-1:0] idx,
    input logic [cfq_pkg::CapW-1:0] cap
  );
    logic [cfq_pkg::CapW-1:0] n;
    n = cfq_pkg::CapW'(idx) + cfq_pkg::CapW'(1);
    if (n >= cap) begin
      n = '0;
    end
    return n[cfq_pkg::IdxW-1:0];
  endfunction

  assign fire        = op_valid_i && (!out_valid_q || out_ready_i);
  assign op_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign is_full  = (cnt_q >= ctrl_i.cap);
  assign is_empty = (cnt_q == '0);
  assign cap_m1   = ctrl_i.cap - cfq_pkg::CapW'(1);

  always_comb begin
    head_d          = head_q;
    tail_d          = tail_q;
    cnt_d           = cnt_q;
    wr_en           = 1'b0;
    out_d           = out_q;
    out_valid_d     = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d     = 1'b1;
      out_d.data_out  = '0;
      out_d.status    = cfq_pkg::StOk;
      case (op_i.kind) inside
        cfq_pkg::OpEnq: begin
          if (is_full) begin
            out_d.status = cfq_pkg::StFull;
          end else begin
            tail_d = next_idx(tail_q, ctrl_i.cap);
            wr_en  = 1'b1;
            cnt_d  = cnt_q + cfq_pkg::CntW'(1);
          end
        end
        cfq_pkg::OpDeq, cfq_pkg::OpPeek: begin
          if (is_empty) begin
            out_d.status = cfq_pkg::StEmpty;
          end else begin
            out_d.data_out = slot_q[head_q];
            if (op_i.kind == cfq_pkg::OpDeq) begin
              head_d = next_idx(head_q, ctrl_i.cap);
              cnt_d  = cnt_q - cfq_pkg::CntW'(1);
            end
          end
        end
        default: begin
        end
      endcase
      out_d.occupancy  = cnt_d;
      out_d.full_flag  = (cnt_d == ctrl_i.cap);
      out_d.empty_flag = (cnt_d == '0);
    end
    // A capacity write empties the queue.
    if (ctrl_i.clr) begin
      head_d = '0;
      tail_d = cap_m1[cfq_pkg::IdxW-1:0];
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= cfq_pkg::IdxW'(cfq_pkg::MaxDepth - 1);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (wr_en) begin
      slot_q[tail_d] <= op_i.data;
    end
  end

`ifndef SYNTHESIS
  // The count clears only after the new capacity applies, so cycles with clr raised are skipped.
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.clr |-> cnt_q <= ctrl_i.cap)
    else $error("occupancy exceeds configured capacity");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (op_i.kind == cfq_pkg::OpEnq) && !is_full && !ctrl_i.clr
    |=> cnt_q == $past(cnt_q) + cfq_pkg::CntW'(1))
    else $error("accepted enqueue did not grow occupancy");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == cfq_pkg::StFull) |-> out_q.full_flag)
    else $error("full rejection reported without full flag");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == cfq_pkg::StEmpty)
    |-> out_q.empty_flag && (out_q.data_out == '0))
    else $error("empty rejection reported with data or without empty flag");
`endif

endmodule

// ----- rtl/circular_fifo_queue_top.sv -----
// An accepted request is held in the operation queue, then executed by the
// back end, which registers its result in the result register.
// Throughput: one request per cycle while results are taken; a held result
// stalls the back end. Each command runs against a flop-based slot store.
// Reset: head, occupancy and handshakes clear at once, capacity returns to
// 16 and the tail to the last slot; stored words are undefined until written.
// ----------------------------------------------------------------------------
// circular_fifo_queue_top
// Circular FIFO of signed 32-bit words with a programmable capacity, an
// APB-style register port, and valid/ready request and result channels.
// ----------------------------------------------------------------------------
module circular_fifo_queue_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cfq_pkg::CfgAddrW-1:0]   paddr,
  input  logic [cfq_pkg::CfgDataW-1:0]   pwdata,
  output logic [cfq_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cfq_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cfq_pkg::out_t                  out_data_o
);

  logic [cfq_pkg::CapW-1:0] cap_q, cap_d;
  logic                     clr_q, clr_d;
  logic                     cfg_wr;
  logic                     reg_sel;
  cfq_pkg::ctrl_t           ctrl;
  logic                     fq_valid, fq_ready;
  cfq_pkg::op_t             fq_op;
  logic                     qb_valid, qb_ready;
  cfq_pkg::op_t             qb_op;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == cfq_pkg::RegCapacity);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign cap_d   = cfg_wr ? pwdata[cfq_pkg::CapW-1:0] : cap_q;
  assign clr_d   = cfg_wr;

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = cfq_pkg::CfgDataW'(cap_q);
    end
  end

  // Zero acts as one slot; anything beyond the built-in depth is clamped.
  always_comb begin
    ctrl.clr = clr_q;
    if (cap_q == '0) begin
      ctrl.cap = cfq_pkg::CapW'(1);
    end else if (cap_q > cfq_pkg::CapW'(cfq_pkg::MaxDepth)) begin
      ctrl.cap = cfq_pkg::CapW'(cfq_pkg::MaxDepth);
    end else begin
      ctrl.cap = cap_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= cfq_pkg::CapW'(cfq_pkg::MaxDepth);
      clr_q <= 1'b0;
    end else begin
      cap_q <= cap_d;
      clr_q <= clr_d;
    end
  end

  cfq_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .op_valid_o (fq_valid),
    .op_ready_i (fq_ready),
    .op_o       (fq_op)
  );

  cfq_op_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_op_i    (fq_op),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_op_o     (qb_op)
  );

  cfq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .op_valid_i  (qb_valid),
    .op_ready_o  (qb_ready),
    .op_i        (qb_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/sv/circular_fifo_queue_top_test.sv -----
// ----------------------------------------------------------------------------
// circular_fifo_queue_top_test
// Self-checking bench for the circular FIFO queue. A clocked driver sends
// command requests in bursts with random gaps, and a clocked monitor scores
// every result against a cycle-free predictor of the queue. The capacity
// register is rewritten between phases, covering zero, one, the full depth
// and values beyond it.
// ----------------------------------------------------------------------------
module circular_fifo_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The command code that the block must treat as a no-op.
  localparam logic [1:0] CmdNone = 2'd3;
  localparam logic [cfq_pkg::CfgAddrW-1:0] AddrCapacity =
    cfq_pkg::CfgAddrW'(4 * cfq_pkg::RegCapacity);
  localparam int IdleLimit  = 2000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [cfq_pkg::CfgAddrW-1:0] paddr = '0;
  logic [cfq_pkg::CfgDataW-1:0] pwdata = '0;
  logic [cfq_pkg::CfgDataW-1:0] prdata;
  logic                         pready;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  cfq_pkg::in_t                 in_data_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  cfq_pkg::out_t                out_data_o;

  circular_fifo_queue_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Predicted queue state.
  logic signed [cfq_pkg::DataW-1:0] q_slots [cfq_pkg::MaxDepth];
  logic [cfq_pkg::CapW-1:0]         q_cap_reg;
  int                               q_head;
  int                               q_tail;
  int                               q_count;

  cfq_pkg::in_t  req_pending [$];
  cfq_pkg::out_t results_due [$];
  int            n_sent = 0;
  int            n_taken = 0;
  int            n_err = 0;

  function automatic int fifo_cap();
    if (q_cap_reg == 0) return 1;
    if (q_cap_reg > cfq_pkg::MaxDepth) return cfq_pkg::MaxDepth;
    return int'(q_cap_reg);
  endfunction

  function automatic int fifo_next(int idx);
    int n;
    n = idx + 1;
    if (n >= fifo_cap()) n = 0;
    return n;
  endfunction

  function automatic void fifo_clear();
    q_head  = 0;
    q_tail  = fifo_cap() - 1;
    q_count = 0;
  endfunction

  function automatic cfq_pkg::out_t fifo_apply(cfq_pkg::in_t req);
    cfq_pkg::out_t res;
    int            cap;
    cap = fifo_cap();
    res = '0;
    res.status = cfq_pkg::StOk;
    if (req.command == cfq_pkg::CmdEnq) begin
      if (q_count >= cap) begin
        res.status = cfq_pkg::StFull;
      end else begin
        q_tail = fifo_next(q_tail);
        q_slots[q_tail] = req.data_in;
        q_count++;
      end
    end else if (req.command == cfq_pkg::CmdDeq || req.command == cfq_pkg::CmdPeek) begin
      if (q_count == 0) begin
        res.status = cfq_pkg::StEmpty;
      end else begin
        res.data_out = q_slots[q_head];
        if (req.command == cfq_pkg::CmdDeq) begin
          q_head = fifo_next(q_head);
          q_count--;
        end
      end
    end
    res.occupancy  = cfq_pkg::CntW'(q_count);
    res.full_flag  = (q_count == cap);
    res.empty_flag = (q_count == 0);
    return res;
  endfunction

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Monitor: scores results and predicts each accepted request.
  always @(posedge clk_i) begin
    cfq_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (results_due.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
        end else begin
          want = results_due.pop_front();
          report_field("data_out", want.data_out, out_data_o.data_out);
          report_field("status", 32'(want.status), 32'(out_data_o.status));
          report_field("occupancy", 32'(want.occupancy), 32'(out_data_o.occupancy));
          report_field("full_flag", 32'(want.full_flag), 32'(out_data_o.full_flag));
          report_field("empty_flag", 32'(want.empty_flag), 32'(out_data_o.empty_flag));
        end
      end
      if (in_valid_i && in_ready_o) begin
        results_due.push_back(fifo_apply(in_data_i));
        n_taken <= n_taken + 1;
      end
    end
  end

  // Driver: bursts of requests separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || n_taken == n_sent) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (req_pending.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= req_pending.pop_front();
        n_sent     <= n_sent + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          case ($urandom_range(0, 7))
            0, 1, 2, 3: gap_left <= 0;
            7:          gap_left <= $urandom_range(4, 20);
            default:    gap_left <= $urandom_range(1, 3);
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: a rotating stall pattern, reloaded whenever the tick counter wraps.
  logic [15:0] stall_pat = '1;
  logic [5:0]  stall_tick = '0;

  always @(negedge clk_i) begin
    if (stall_tick == 0) begin
      stall_pat   <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      out_ready_i <= 1'b1;
    end else begin
      stall_pat   <= {stall_pat[0], stall_pat[15:1]};
      out_ready_i <= stall_pat[0];
    end
    stall_tick <= stall_tick + 1'b1;
  end

  // Watchdog on cycles without any accepted request or result.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("circular_fifo_queue_top_test: errors");
        $finish;
      end
    end
  end

  function automatic void push_req(logic [1:0] cmd, logic [31:0] word);
    cfq_pkg::in_t req;
    req.command = cmd;
    req.data_in = word;
    req_pending.push_back(req);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Runs of enqueues, dequeues, peeks and random commands sized to the capacity, so the queue
  // swings between full and empty and both indices wrap often.
  task automatic queue_random_mix(int n_items);
    int         made;
    int         run;
    int         kind;
    int         k;
    logic [1:0] cmd;
    made = 0;
    while (made < n_items) begin
      kind = $urandom_range(0, 5);
      run  = $urandom_range(1, fifo_cap() + 2);
      for (k = 0; k < run && made < n_items; k++) begin
        case (kind)
          0, 1:    cmd = cfq_pkg::CmdEnq;
          2:       cmd = cfq_pkg::CmdDeq;
          3:       cmd = ($urandom_range(0, 3) == 0) ? cfq_pkg::CmdPeek : cfq_pkg::CmdDeq;
          default: cmd = 2'($urandom);
        endcase
        push_req(cmd, rand_word());
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    while (req_pending.size() != 0 || n_taken != n_sent || results_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [cfq_pkg::CfgAddrW-1:0] addr, logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == AddrCapacity) begin
      q_cap_reg = value[cfq_pkg::CapW-1:0];
      fifo_clear();
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  logic [31:0] cap_settings [9];
  int          k;

  initial begin
    foreach (q_slots[i]) q_slots[i] = '0;
    q_cap_reg = cfq_pkg::CapW'(cfq_pkg::MaxDepth);
    fifo_clear();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty-queue rejects, the no-op, extreme words, then fill past full.
    push_req(cfq_pkg::CmdDeq, 32'h0);
    push_req(cfq_pkg::CmdPeek, 32'hFFFF_FFFF);
    push_req(CmdNone, 32'h1234_5678);
    push_req(cfq_pkg::CmdEnq, 32'h7FFF_FFFF);
    push_req(cfq_pkg::CmdEnq, 32'h8000_0000);
    push_req(cfq_pkg::CmdPeek, 32'h0);
    push_req(cfq_pkg::CmdDeq, 32'h0);
    push_req(cfq_pkg::CmdDeq, 32'h0);
    push_req(cfq_pkg::CmdEnq, 32'hFFFF_FFFF);
    for (k = 0; k < cfq_pkg::MaxDepth; k++)
      push_req(cfq_pkg::CmdEnq, (k % 2 == 0) ? 32'h0 : $urandom);
    push_req(cfq_pkg::CmdPeek, 32'h0);
    push_req(CmdNone, 32'hFFFF_FFFF);
    wait_drained();

    // A capacity write must also empty a queue that still holds words.
    cap_settings = '{32'd1, 32'd0, 32'd31, 32'd2, 32'hFFFF_FFF1, 32'd5,
                     32'd16, 32'hFFFF_FFE3, 32'd0};
    cap_settings[8] = $urandom;
    foreach (cap_settings[p]) begin
      cfg_write(AddrCapacity, cap_settings[p]);
      queue_random_mix(105);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (n_err == 0 && results_due.size() == 0)
      $display("circular_fifo_queue_top_test: clean");
    else
      $display("circular_fifo_queue_top_test: errors");
    $finish;
  end

endmodule
